### rtl/sem_pkg.sv
// shared constants and types of the sobel edge magnitude block
// no dependencies
package sem_pkg;

    localparam int CFG_W       = 11;
    localparam int PIX_W       = 8;
    localparam int MAX_W_DEF   = 1024;
    localparam int MAX_H_DEF   = 1024;
    localparam int DEF_WIDTH   = 640;
    localparam int DEF_HEIGHT  = 480;
    localparam int GRAD_W      = 12;
    localparam int SUM_W       = 22;
    localparam int SQ_SAT      = 65280;
    localparam int MAG_SAT     = 255;

    // register indexes of the configuration port
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    // window order: row-major, top row first
    typedef logic signed [2:0] t_coef;
    localparam t_coef KX [9] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                                 -3'sd1, 3'sd0, 3'sd1};
    localparam t_coef KY [9] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                 3'sd1, 3'sd2, 3'sd1};

    typedef logic [8:0][PIX_W-1:0] t_win_ch;

    // handshake between the sequencer and a magnitude unit
    typedef struct packed {
        logic start;
    } t_mag_req;

endpackage

### rtl/sem_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/sem_mag.sv
// one-channel sobel gradient and rounded root unit, bit-serial root
// depends on sem_pkg
module sem_mag (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sem_pkg::t_mag_req i_req,
    input  sem_pkg::t_win_ch  i_win,
    output logic              o_busy,
    output logic [7:0]        o_mag
);
    import sem_pkg::*;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQ   = 2'd1;
    localparam logic [1:0] M_ROOT = 2'd2;
    localparam logic [1:0] M_RND  = 2'd3;

    logic [1:0]               r_st;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [SUM_W-1:0]         r_s;
    logic [7:0]               r_n;
    logic [2:0]               r_k;
    logic [7:0]               r_mag;

    logic signed [GRAD_W-1:0] gx_c, gy_c;
    logic signed [23:0]       gx2, gy2;
    logic [23:0]              s_sum;
    logic [7:0]               t;
    logic [15:0]              tt;
    logic [16:0]              nn;
    logic [8:0]               mag9;

    always_comb begin
        gx_c = '0;
        gy_c = '0;
        for (int i = 0; i < 9; i++) begin
            gx_c = gx_c + GRAD_W'(KX[i]) * $signed({4'b0, i_win[i]});
            gy_c = gy_c + GRAD_W'(KY[i]) * $signed({4'b0, i_win[i]});
        end
    end

    assign gx2   = r_gx * r_gx;
    assign gy2   = r_gy * r_gy;
    assign s_sum = $unsigned(gx2) + $unsigned(gy2);
    assign t     = r_n | (8'd1 << r_k);
    assign tt    = t * t;
    assign nn    = 17'(r_n * r_n) + 17'(r_n);
    assign mag9  = (r_s > SUM_W'(SQ_SAT)) ? 9'(MAG_SAT)
                 : ((r_s > SUM_W'(nn)) ? 9'(r_n) + 9'd1 : 9'(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            case (r_st)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_gx <= gx_c;
                        r_gy <= gy_c;
                        r_st <= M_SQ;
                    end
                end
                M_SQ: begin
                    r_s  <= s_sum[SUM_W-1:0];
                    r_n  <= '0;
                    r_k  <= 3'd7;
                    r_st <= M_ROOT;
                end
                M_ROOT: begin
                    if ({6'b0, tt} <= r_s) begin
                        r_n <= t;
                    end
                    if (r_k == 3'd0) begin
                        r_st <= M_RND;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end
                M_RND: begin
                    r_mag <= mag9[8] ? 8'(MAG_SAT) : mag9[7:0];
                    r_st  <= M_IDLE;
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != M_IDLE);
    assign o_mag  = r_mag;
endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// top level of the rgb sobel edge magnitude block
// depends on sem_pkg, sem_ram, sem_mag
//
// Streams rgb pixels of a frame_width x frame_height frame in raster order and returns, per
// channel, round(sqrt(gx^2+gy^2)) of the 3x3 sobel kernels, saturated at 255, with pixels
// outside the frame taken as zero. Results lag the input by one row plus one pixel, so after
// the last pixel send width+1 words with flush set; the final result carries frame_last.
// Words are handled one at a time: a pixel word that produces a result goes through line
// store read, window update, gradient, square, eight root steps, rounding and output load,
// one that does not only through the read and the window update; a flush word during the
// pixel phase is dropped in its accept cycle. Most steps are those of the bit-serial root.
// The two line stores share one ram word (upper row, middle row) read and rewritten per pixel;
// the next read is only issued after the write-back, so no forwarding is needed. A
// configuration write restarts the frame and is meant to be issued while the block is idle.
// A finished result sits in an output register, so the next word is taken while it waits.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_W_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_H_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel_red,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel_green,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel_blue,
    input  logic                          i_flush,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sem_pkg::PIX_W-1:0]     o_edge_red,
    output logic [sem_pkg::PIX_W-1:0]     o_edge_green,
    output logic [sem_pkg::PIX_W-1:0]     o_edge_blue,
    output logic                          o_frame_last,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data
);
    import sem_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int OW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = 3 * PIX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_START = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    // config and control state
    logic [CFG_W-1:0]       r_cfg_w, r_cfg_h;
    logic [1:0]             r_state;
    logic [CW-1:0]          r_in_col;
    logic [RW-1:0]          r_in_row;
    logic [CW-1:0]          r_out_col;
    logic [OW-1:0]          r_out_row;
    logic [CW-1:0]          r_c;
    logic [PW-1:0]          r_pix;
    logic [8:0][PW-1:0]     r_window;
    logic [8:0][PW-1:0]     r_win;
    logic                   r_o_valid;
    logic [PIX_W-1:0]       r_o_red, r_o_green, r_o_blue;
    logic                   r_o_last;

    logic [DW-1:0]          w;
    logic [HW-1:0]          h;
    logic                   accept, drain, take;
    logic [CW-1:0]          c_acc;
    logic [2*PW-1:0]        rd_data;
    logic [PW-1:0]          top, mid;
    logic [8:0][PW-1:0]     n_window, n_win;
    logic [CW:0]            col_inc;
    logic                   emit, out_free, last;
    t_mag_req               mag_req;
    logic [2:0]             mag_busy;
    logic [PIX_W-1:0]       mag_r, mag_g, mag_b;
    t_win_ch                win_r, win_g, win_b;

    // clamp the dimensions into 1..max
    always_comb begin
        if (r_cfg_w == '0) begin
            w = DW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = DW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(r_cfg_h);
        end
    end

    assign drain  = 32'(r_in_row) >= 32'(h);
    assign accept = i_valid && (r_state == S_IDLE);
    // a flush word before the frame is complete is dropped
    assign take   = accept && (drain || !i_flush);
    assign c_acc  = (32'(r_in_col) >= 32'(w)) ? '0 : r_in_col;

    // line stores: {upper row, middle row} per column
    sem_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_c),
        .i_wdata ({mid, r_pix}),
        .i_re    (take),
        .i_raddr (c_acc),
        .o_rdata (rd_data)
    );

    // rows above the frame read as zero
    assign top = (r_in_row < RW'(2)) ? '0 : rd_data[2*PW-1:PW];
    assign mid = (r_in_row < RW'(1)) ? '0 : rd_data[PW-1:0];

    // window shift; a row start closes the previous row with a zero column
    always_comb begin
        n_window = r_window;
        n_win    = r_win;
        for (int r = 0; r < 3; r++) begin
            if (r_c == '0) begin
                n_win[r*3]       = r_window[r*3+1];
                n_win[r*3+1]     = r_window[r*3+2];
                n_win[r*3+2]     = '0;
                n_window[r*3]    = '0;
                n_window[r*3+1]  = '0;
            end else begin
                n_window[r*3]    = r_window[r*3+1];
                n_window[r*3+1]  = r_window[r*3+2];
            end
        end
        n_window[2] = top;
        n_window[5] = mid;
        n_window[8] = r_pix;
        if (r_c != '0) begin
            n_win = n_window;
        end
    end

    assign col_inc = {1'b0, r_c} + (CW+1)'(1);
    assign emit    = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_c != '0));

    assign out_free = !r_o_valid || !i_stall;
    assign last     = (32'(r_out_row) + 32'd1 >= 32'(h))
                   && (32'(r_out_col) + 32'd1 >= 32'(w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= CFG_W'(DEF_WIDTH);
            r_cfg_h   <= CFG_W'(DEF_HEIGHT);
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_window  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_c     <= c_acc;
                        r_pix   <= drain ? '0 : {i_pixel_blue, i_pixel_green, i_pixel_red};
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_window <= n_window;
                    r_win    <= n_win;
                    if (32'(col_inc) >= 32'(w)) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + RW'(1);
                    end else begin
                        r_in_col <= col_inc[CW-1:0];
                    end
                    r_state <= emit ? S_START : S_IDLE;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if ((mag_busy == 3'b000) && out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_red   <= mag_r;
                        r_o_green <= mag_g;
                        r_o_blue  <= mag_b;
                        r_o_last  <= last;
                        r_state   <= S_IDLE;
                        if (last) begin
                            // frame done: restart for the next one
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_window  <= '0;
                        end else if (32'(r_out_col) + 32'd1 >= 32'(w)) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + OW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // a register write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_window  <= '0;
            end
        end
    end

    // split the window into its color planes
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            win_r[i] = r_win[i][PIX_W-1:0];
            win_g[i] = r_win[i][2*PIX_W-1:PIX_W];
            win_b[i] = r_win[i][PW-1:2*PIX_W];
        end
    end

    assign mag_req.start = (r_state == S_START);

    sem_mag u_mag_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mag_req),
        .i_win   (win_r),
        .o_busy  (mag_busy[0]),
        .o_mag   (mag_r)
    );

    sem_mag u_mag_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mag_req),
        .i_win   (win_g),
        .o_busy  (mag_busy[1]),
        .o_mag   (mag_g)
    );

    sem_mag u_mag_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mag_req),
        .i_win   (win_b),
        .o_busy  (mag_busy[2]),
        .o_mag   (mag_b)
    );

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_edge_red   = r_o_red;
    assign o_edge_green = r_o_green;
    assign o_edge_blue  = r_o_blue;
    assign o_frame_last = r_o_last;
endmodule

### rtl/sem_chk.sv
// port-level checker for the sobel edge magnitude block, bound to the top level
// depends on sem_pkg
module sem_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_flush,
    input logic                          o_stall,
    input logic [sem_pkg::PIX_W-1:0]     o_edge_red,
    input logic [sem_pkg::PIX_W-1:0]     o_edge_green,
    input logic [sem_pkg::PIX_W-1:0]     o_edge_blue,
    input logic                          o_frame_last,
    input logic                          o_valid,
    input logic                          i_stall
);
    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_edge_red) && $stable(o_edge_green)
                               && $stable(o_edge_blue) && $stable(o_frame_last))
        else $error("stalled result word changed");

    // an accepted pixel word keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_flush |=> o_stall)
        else $error("input accepted back to back");

    // no result can appear in the cycle after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");
endmodule

bind sobel_edge_magnitude_rgb sem_chk u_sem_chk (.*);

### tb/tb_top.sv
// self-checking testbench of the rgb sobel edge magnitude block
// depends on sem_pkg and sobel_edge_magnitude_rgb
`timescale 1ns / 1ps

module tb_top;
    import sem_pkg::*;

    localparam int LINE_MAX   = MAX_W_DEF;
    localparam int ROWS_MAX   = MAX_H_DEF;
    localparam int HOLD_LONG  = 400;
    localparam int IDLE_WAIT  = 30;
    localparam int CYCLE_CAP  = 1500000;
    localparam int RAND_WORDS = 1550;

    // one result word as the block should deliver it
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_word_t;

    // one row of the directed table
    typedef struct {
        bit          cfg;
        logic [10:0] wid;
        logic [10:0] hgt;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        bit          f;
        bit          typed;
        edge_word_t  exp;
    } dir_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_pixel_red = '0;
    logic [7:0] i_pixel_green = '0;
    logic [7:0] i_pixel_blue = '0;
    logic       i_flush = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_edge_red;
    logic [7:0] o_edge_green;
    logic [7:0] o_edge_blue;
    logic       o_frame_last;
    logic       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    sobel_edge_magnitude_rgb u_top (.*);

    always #1 i_clk = ~i_clk;

    // ---------------- edge predictor ----------------
    // own copy of line stores, window, counters and frame size
    logic [23:0] top_row_mem [LINE_MAX];
    logic [23:0] mid_row_mem [LINE_MAX];
    logic [23:0] win_px [9];
    int unsigned frame_w, frame_h;
    int unsigned col_in, row_in, col_out, row_out;

    // sobel kernels, row-major, top row first
    const int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    const int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    edge_word_t edge_q [$];
    int errors = 0;
    int cycles = 0;
    bit hold_go = 0;
    bit quiet_tx = 0;

    function automatic int unsigned fix_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic restart_frame();
        foreach (win_px[i]) win_px[i] = '0;
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    endtask

    // rounded integer root, saturated at 255
    function automatic logic [7:0] rounded_root(int unsigned s);
        int unsigned n;
        int unsigned t;
        n = 0;
        if (s > 65280) return 8'd255;
        for (int bitv = 128; bitv != 0; bitv >>= 1) begin
            t = n | bitv;
            if (t * t <= s) n = t;
        end
        if (s > n * n + n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic logic [7:0] chan_edge(logic [23:0] w [9], int sh);
        int gx, gy, p;
        gx = 0; gy = 0;
        for (int i = 0; i < 9; i++) begin
            p = int'((w[i] >> sh) & 24'hff);
            gx += kx[i] * p;
            gy += ky[i] * p;
        end
        return rounded_root(gx * gx + gy * gy);
    endfunction

    task automatic predict_edge(input logic [7:0] r, g, b, input bit f,
                                output bit has, output edge_word_t e);
        int unsigned w, h, c;
        bit drain, last;
        logic [23:0] pix, top, mid;
        logic [23:0] win [9];
        w = fix_dim(frame_w, LINE_MAX);
        h = fix_dim(frame_h, ROWS_MAX);
        drain = row_in >= h;
        has = 0;
        e = '{default: '0};
        if (!drain && f) return;
        pix = drain ? 24'd0 : {b, g, r};
        c = col_in;
        if (c >= w) c = 0;
        top = (row_in < 2) ? 24'd0 : top_row_mem[c];
        mid = (row_in < 1) ? 24'd0 : mid_row_mem[c];
        top_row_mem[c] = mid;
        mid_row_mem[c] = pix;
        if (c == 0) begin
            // row start: previous row closes with an out-of-frame column
            for (int k = 0; k < 3; k++) begin
                win[k*3]   = win_px[k*3+1];
                win[k*3+1] = win_px[k*3+2];
                win[k*3+2] = '0;
            end
            foreach (win_px[i]) win_px[i] = '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                win_px[k*3]   = win_px[k*3+1];
                win_px[k*3+1] = win_px[k*3+2];
            end
        end
        win_px[2] = top;
        win_px[5] = mid;
        win_px[8] = pix;
        if (c != 0) win = win_px;
        has = (row_in >= 2) || (row_in == 1 && c >= 1);
        col_in = c + 1;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        if (!has) return;
        e.red   = chan_edge(win, 0);
        e.green = chan_edge(win, 8);
        e.blue  = chan_edge(win, 16);
        last = (row_out + 1 >= h) && (col_out + 1 >= w);
        e.last = last;
        if (last) restart_frame();
        else begin
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out++;
            end
        end
    endtask

    // ---------------- timeout ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- result side ----------------
    // random stall runs, plus one long hold-off on request
    int stall_left = 0;
    int free_left = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_LONG;
            hold_go = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b0;
            free_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 6);
            stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        edge_word_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (edge_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = edge_q.pop_front();
                if (o_edge_red !== e.red) begin
                    $error("edge_red exp %0d got %0d", e.red, o_edge_red);
                    errors++;
                end
                if (o_edge_green !== e.green) begin
                    $error("edge_green exp %0d got %0d", e.green, o_edge_green);
                    errors++;
                end
                if (o_edge_blue !== e.blue) begin
                    $error("edge_blue exp %0d got %0d", e.blue, o_edge_blue);
                    errors++;
                end
                if (o_frame_last !== e.last) begin
                    $error("frame_last exp %0d got %0d", e.last, o_frame_last);
                    errors++;
                end
            end
        end
    end

    // ---------------- pixel side ----------------
    function automatic int pick_gap();
        int k;
        if (quiet_tx) return 0;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // wait until every expected word has come and the block has settled
    task automatic drain_wait();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) frame_w = 32'(val);
        else frame_h = 32'(val);
        restart_frame();
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        drain_wait();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // send one word; typed expectation replaces the predicted one when given
    task automatic send_word(input logic [7:0] r, g, b, input bit f,
                             input bit typed, input edge_word_t te);
        bit has;
        edge_word_t e;
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel_red <= r;
        i_pixel_green <= g;
        i_pixel_blue <= b;
        i_flush <= f;
        do @(posedge i_clk); while (o_stall);
        predict_edge(r, g, b, f, has, e);
        if (typed) edge_q.push_back(te);
        else if (has) edge_q.push_back(e);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] rand_chan(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            1: return $urandom_range(0, 255) < 128 ? 8'h00 : 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame of random content with some noise and optional early cut
    task automatic rand_frame(input logic [10:0] w, input logic [10:0] h, input bit cut,
                              inout int sent);
        int unsigned npix, nflush, stop;
        int mode;
        edge_word_t none;
        none = '{default: '0};
        set_frame(w, h);
        npix = fix_dim(32'(w), LINE_MAX) * fix_dim(32'(h), ROWS_MAX);
        nflush = fix_dim(32'(w), LINE_MAX) + 1;
        stop = cut ? $urandom_range(1, npix + nflush - 1) : npix + nflush;
        mode = $urandom_range(0, 4);
        quiet_tx = $urandom_range(0, 3) == 0;
        for (int unsigned i = 0; i < npix + nflush && i < stop; i++) begin
            // stray flush while pixels are still due
            if (i < npix && $urandom_range(0, 19) == 0)
                send_word(rand_chan(2), rand_chan(2), rand_chan(2), 1'b1, 0, none);
            if (i < npix || $urandom_range(0, 3) == 0)
                send_word(rand_chan(mode), rand_chan(mode), rand_chan(mode), 1'b0, 0, none);
            else
                send_word(rand_chan(2), rand_chan(2), rand_chan(2), 1'b1, 0, none);
            sent++;
        end
        quiet_tx = 0;
    endtask

    dir_row_t dir_tab [$];

    initial begin
        edge_word_t none;
        edge_word_t zero_last;
        int sent;
        none = '{default: '0};
        zero_last = '{red: 8'd0, green: 8'd0, blue: 8'd0, last: 1'b1};
        frame_w = DEF_WIDTH;
        frame_h = DEF_HEIGHT;
        foreach (top_row_mem[i]) top_row_mem[i] = '0;
        foreach (mid_row_mem[i]) mid_row_mem[i] = '0;
        restart_frame();

        // 1x1 frame: stray flush, bright pixel, pixel in drain, flush;
        // the center tap has zero weight so the lone result is zero
        dir_tab.push_back('{1, 11'd1, 11'd1, 8'h00, 8'h00, 8'h00, 1, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'hff, 8'hff, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'h00, 8'hff, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 1, 1, zero_last});
        // zero size counts as one
        dir_tab.push_back('{1, 11'd0, 11'd0, 8'h80, 8'h01, 8'hfe, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 1, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 1, 1, zero_last});
        // 3x2 frame with extreme and mixed values
        dir_tab.push_back('{1, 11'd3, 11'd2, 8'h00, 8'hff, 8'h00, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'h00, 8'hff, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'h00, 8'hff, 8'h55, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'hff, 8'haa, 1, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'hff, 8'haa, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'h00, 8'h00, 8'h0f, 0, 0, none});
        dir_tab.push_back('{0, 11'd0, 11'd0, 8'hff, 8'h00, 8'hf0, 0, 0, none});
        for (int i = 0; i < 4; i++)
            dir_tab.push_back('{0, 11'd0, 11'd0, 8'h12, 8'h34, 8'h56, i[0], 0, none});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) set_frame(dir_tab[i].wid, dir_tab[i].hgt);
            send_word(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].f,
                      dir_tab[i].typed, dir_tab[i].exp);
        end

        sent = 0;
        // tall one-column frame under a long receiver hold-off, so the input backs up;
        // the oversized height clamps to the maximum
        drain_wait();
        hold_go = 1;
        rand_frame(11'd1, 11'd2047, 0, sent);
        while (sent < RAND_WORDS) begin
            rand_frame(11'($urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                     : $urandom_range(1, 8)),
                       11'($urandom_range(0, 7)), $urandom_range(0, 9) == 0, sent);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_wait();
        if (errors == 0 && edge_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
